@@ design/polygon_clip_sutherland_hodgman_core_macros.svh @@
// Assertion macros for the polygon clipper core.
// Depends on nothing; the user supplies clk and arst_n in scope.
`ifndef POLYGON_CLIP_SUTHERLAND_HODGMAN_CORE_MACROS_SVH
`define POLYGON_CLIP_SUTHERLAND_HODGMAN_CORE_MACROS_SVH

// Check in the same cycle.
`define SHC_ASSERT_NOW(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

// Check in the following cycle.
`define SHC_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

@@ design/shc_pkg.sv @@
// Shared constants and types of the polygon clipper core.
// Depends on nothing.
package shc_pkg;

	localparam int CoordBits    = 12;
	localparam int MaxVerts     = 32;
	localparam int MaxClipVerts = 16;

	localparam int VertW   = 2 * CoordBits;
	localparam int CntW    = $clog2(MaxVerts + 1);
	localparam int IdxW    = $clog2(MaxVerts);
	localparam int CCntW   = $clog2(MaxClipVerts + 1);
	localparam int CIdxW   = $clog2(MaxClipVerts);

	localparam int MulAW   = 2 * CoordBits + 1;
	localparam int MulBW   = CoordBits + 1;
	localparam int ProdW   = MulAW + MulBW;
	localparam int AccW    = ProdW + 1;
	localparam int DenW    = 2 * CoordBits + 3;
	localparam int DivCntW = $clog2(AccW + 1);

	localparam int DataW   = ((VertW + 7) / 8) * 8;
	localparam int SUserW  = 2;
	localparam int MUserW  = 2;

	localparam int UserEmpty = 0;
	localparam int UserOvf   = 1;

	typedef enum logic [1:0] {
		ACT_LOAD_SUBJ = 2'd0,
		ACT_LOAD_CLIP = 2'd1,
		ACT_CLIP      = 2'd2
	} action_t;

	typedef struct packed {
		logic signed [CoordBits-1:0] y;
		logic signed [CoordBits-1:0] x;
	} vertex_t;

endpackage

@@ design/shc_ram.sv @@
// Generic single-write, single-read memory with registered read data.
// Depends on nothing.
module shc_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];
	logic [Width-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ design/polygon_clip_sutherland_hodgman_core.sv @@
// Sutherland-Hodgman clipper: load words are accepted one per cycle, back to back,
// while idle. A clip word blocks input while every clipper edge runs over every
// subject edge on one shared multiplier and one bit-serial divider, and while
// the result vertices are emitted. Async active-low reset clears counts, flags
// and control state.
// Depends on shc_pkg, shc_ram and the macros header.
`include "polygon_clip_sutherland_hodgman_core_macros.svh"

module polygon_clip_sutherland_hodgman_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [shc_pkg::DataW-1:0]        s_tdata,  // vertex_x, vertex_y, zero pad
	input  logic [shc_pkg::SUserW-1:0]       s_tuser,  // action
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [shc_pkg::DataW-1:0]        m_tdata,  // out_x, out_y, zero pad
	output logic [shc_pkg::MUserW-1:0]       m_tuser,  // empty_result, overflow
	output logic                             m_tlast
);

	localparam int CW = shc_pkg::CoordBits;

	typedef enum logic [4:0] {
		S_IDLE, S_CRD_A, S_CRD_B, S_CLAT,
		S_JOB0, S_JOB1, S_JOB2,
		S_RD_FIRST, S_LAT_FIRST, S_RD_E, S_LAT_E, S_DECIDE,
		S_DIV, S_PUSH_I, S_PUSH_E, S_ADV, S_PASS_END,
		S_EMIT_RD, S_EMIT_LAT, S_EMIT_WAIT
	} state_t;

	// Each job forms t0 - t1 from two products of the shared multiplier.
	typedef enum logic [2:0] {
		J_CAB, J_SIDE, J_CPQ, J_DEN, J_NUMX, J_NUMY
	} job_t;

	state_t state_q;
	job_t   job_q;

	logic [shc_pkg::CntW-1:0]  scount_q, m_q, i_q, k_q;
	logic [shc_pkg::CCntW-1:0] ccount_q, p_q;
	logic                      ovf_q, bank_q, side_first_q;

	shc_pkg::vertex_t a_q, b_q, s_q, e_q, first_q, ivert_q;
	logic signed [CW:0] dxab_q, dyab_q;
	logic s_in_q, e_in_q;

	logic signed [shc_pkg::MulAW-1:0] cab_q, cpq_q;
	logic signed [shc_pkg::DenW-1:0]  den_q;
	logic signed [shc_pkg::ProdW-1:0] prod_s1;
	logic signed [shc_pkg::AccW-1:0]  acc_q, res;

	// Divider state.
	logic [shc_pkg::AccW-1:0]    nq_q;
	logic [shc_pkg::DenW-1:0]    dmag_q, rem_q;
	logic [shc_pkg::DivCntW-1:0] div_cnt_q;
	logic                        div_neg_q, div_zero_q, div_y_q;

	// Output register.
	logic                   out_valid_q, out_last_q, out_empty_q, out_ovf_q;
	shc_pkg::vertex_t       out_vert_q;

	// Memories.
	logic                     subj_we [2];
	logic [shc_pkg::IdxW-1:0] subj_waddr, subj_raddr;
	shc_pkg::vertex_t         subj_wdata;
	logic [shc_pkg::VertW-1:0] subj_rdata [2];
	shc_pkg::vertex_t         subj_rd;
	logic                     clip_we;
	logic [shc_pkg::CIdxW-1:0] clip_raddr;
	shc_pkg::vertex_t         clip_rd;
	logic [shc_pkg::VertW-1:0] clip_rdata;

	shc_pkg::vertex_t  in_vert;
	shc_pkg::action_t  in_act;
	logic              in_acc;

	assign in_vert  = s_tdata[shc_pkg::VertW-1:0];
	assign in_act   = shc_pkg::action_t'(s_tuser);
	assign s_tready = (state_q == S_IDLE);
	assign in_acc   = s_tvalid && s_tready;

	assign subj_rd = bank_q ? subj_rdata[1] : subj_rdata[0];
	assign clip_rd = clip_rdata;

	// Write port: loads go to the current bank, pushes to the other one.
	logic push_en;
	logic load_subj;
	assign load_subj = in_acc && (in_act == shc_pkg::ACT_LOAD_SUBJ) &&
		(scount_q < shc_pkg::CntW'(shc_pkg::MaxVerts));
	assign push_en = ((state_q == S_PUSH_I) || (state_q == S_PUSH_E)) &&
		(m_q < shc_pkg::CntW'(shc_pkg::MaxVerts));

	always_comb begin
		subj_we[0] = 1'b0;
		subj_we[1] = 1'b0;
		subj_waddr = scount_q[shc_pkg::IdxW-1:0];
		subj_wdata = in_vert;
		if (load_subj) begin
			subj_we[bank_q] = 1'b1;
		end else if (push_en) begin
			subj_we[!bank_q] = 1'b1;
			subj_waddr = m_q[shc_pkg::IdxW-1:0];
			subj_wdata = (state_q == S_PUSH_I) ? ivert_q : e_q;
		end
	end

	always_comb begin
		case (state_q)
			S_RD_E:    subj_raddr = shc_pkg::IdxW'(i_q + 1'b1);
			S_EMIT_RD: subj_raddr = k_q[shc_pkg::IdxW-1:0];
			default:   subj_raddr = '0;
		endcase
	end

	assign clip_we = in_acc && (in_act == shc_pkg::ACT_LOAD_CLIP) &&
		(ccount_q < shc_pkg::CCntW'(shc_pkg::MaxClipVerts));

	// Wrap to vertex 0 on the closing clipper edge.
	logic [shc_pkg::CCntW-1:0] p_next;
	assign p_next = p_q + 1'b1;
	always_comb begin
		if (state_q == S_CRD_B) begin
			clip_raddr = (p_next == ccount_q) ? '0 : p_next[shc_pkg::CIdxW-1:0];
		end else begin
			clip_raddr = p_q[shc_pkg::CIdxW-1:0];
		end
	end

	for (genvar g = 0; g < 2; g++) begin : g_subj
		shc_ram #(.Width(shc_pkg::VertW), .Depth(shc_pkg::MaxVerts)) u_subj (
			.clk   (clk),
			.we    (subj_we[g]),
			.waddr (subj_waddr),
			.wdata (subj_wdata),
			.raddr (subj_raddr),
			.rdata (subj_rdata[g])
		);
	end

	shc_ram #(.Width(shc_pkg::VertW), .Depth(shc_pkg::MaxClipVerts)) u_clip (
		.clk   (clk),
		.we    (clip_we),
		.waddr (ccount_q[shc_pkg::CIdxW-1:0]),
		.wdata (in_vert),
		.raddr (clip_raddr),
		.rdata (clip_rdata)
	);

	// Shared multiplier operand select.
	logic signed [shc_pkg::MulAW-1:0] op_a;
	logic signed [shc_pkg::MulBW-1:0] op_b;
	logic signed [CW:0] dxpq, dypq, epx, epy;
	logic term1;

	assign dxpq  = (CW+1)'(s_q.x) - (CW+1)'(e_q.x);
	assign dypq  = (CW+1)'(s_q.y) - (CW+1)'(e_q.y);
	assign epx   = (CW+1)'(e_q.x) - (CW+1)'(a_q.x);
	assign epy   = (CW+1)'(e_q.y) - (CW+1)'(a_q.y);
	assign term1 = (state_q == S_JOB1);

	always_comb begin
		case (job_q)
			J_CAB: begin
				op_a = term1 ? shc_pkg::MulAW'(a_q.y) : shc_pkg::MulAW'(a_q.x);
				op_b = term1 ? shc_pkg::MulBW'(b_q.x) : shc_pkg::MulBW'(b_q.y);
			end
			J_SIDE: begin
				op_a = term1 ? shc_pkg::MulAW'(epy) : shc_pkg::MulAW'(epx);
				op_b = term1 ? dxab_q : dyab_q;
			end
			J_CPQ: begin
				op_a = term1 ? shc_pkg::MulAW'(s_q.y) : shc_pkg::MulAW'(s_q.x);
				op_b = term1 ? shc_pkg::MulBW'(e_q.x) : shc_pkg::MulBW'(e_q.y);
			end
			J_DEN: begin
				op_a = term1 ? shc_pkg::MulAW'(dxpq) : shc_pkg::MulAW'(dypq);
				op_b = term1 ? dyab_q : dxab_q;
			end
			J_NUMX: begin
				op_a = term1 ? cpq_q : cab_q;
				op_b = term1 ? dxab_q : dxpq;
			end
			J_NUMY: begin
				op_a = term1 ? cpq_q : cab_q;
				op_b = term1 ? dyab_q : dypq;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign res = acc_q - shc_pkg::AccW'(prod_s1);

	// Divider step and saturated quotient.
	logic [shc_pkg::DenW:0]    rem_sh;
	logic                      q_bit;
	logic [shc_pkg::AccW-1:0]  num_mag;
	logic [shc_pkg::DenW-1:0]  den_mag;
	logic signed [CW-1:0]      quot;
	localparam logic [shc_pkg::AccW-1:0] PosLim = shc_pkg::AccW'((2 ** (CW - 1)) - 1);
	localparam logic [shc_pkg::AccW-1:0] NegLim = shc_pkg::AccW'(2 ** (CW - 1));

	assign rem_sh  = {rem_q, nq_q[shc_pkg::AccW-1]};
	assign q_bit   = (rem_sh >= {1'b0, dmag_q});
	assign num_mag = res[shc_pkg::AccW-1] ? (~res + 1'b1) : res;
	assign den_mag = den_q[shc_pkg::DenW-1] ? (~den_q + 1'b1) : den_q;

	always_comb begin
		if (div_zero_q) begin
			quot = '0;
		end else if (!div_neg_q) begin
			quot = (nq_q > PosLim) ? PosLim[CW-1:0] : nq_q[CW-1:0];
		end else begin
			quot = (nq_q > NegLim) ? NegLim[CW-1:0] : -nq_q[CW-1:0];
		end
	end

	logic last_e;
	assign last_e = ((i_q + 1'b1) == scount_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			job_q        <= J_CAB;
			scount_q     <= '0;
			ccount_q     <= '0;
			ovf_q        <= 1'b0;
			bank_q       <= 1'b0;
			m_q          <= '0;
			p_q          <= '0;
			i_q          <= '0;
			k_q          <= '0;
			side_first_q <= 1'b0;
			div_cnt_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						case (in_act)
							shc_pkg::ACT_LOAD_SUBJ: begin
								if (load_subj) begin
									scount_q <= scount_q + 1'b1;
								end else begin
									ovf_q <= 1'b1;
								end
							end
							shc_pkg::ACT_LOAD_CLIP: begin
								if (clip_we) begin
									ccount_q <= ccount_q + 1'b1;
								end
							end
							shc_pkg::ACT_CLIP: begin
								p_q     <= '0;
								m_q     <= '0;
								k_q     <= '0;
								state_q <= (ccount_q == '0) ? S_EMIT_RD : S_CRD_A;
							end
							default: ;
						endcase
					end
				end
				S_CRD_A: state_q <= S_CRD_B;
				S_CRD_B: begin
					a_q     <= clip_rd;
					state_q <= S_CLAT;
				end
				S_CLAT: begin
					b_q     <= clip_rd;
					dxab_q  <= (CW+1)'(a_q.x) - (CW+1)'(clip_rd.x);
					dyab_q  <= (CW+1)'(a_q.y) - (CW+1)'(clip_rd.y);
					job_q   <= J_CAB;
					state_q <= S_JOB0;
				end
				S_JOB0: begin
					prod_s1 <= op_a * op_b;
					state_q <= S_JOB1;
				end
				S_JOB1: begin
					acc_q   <= shc_pkg::AccW'(prod_s1);
					prod_s1 <= op_a * op_b;
					state_q <= S_JOB2;
				end
				S_JOB2: begin
					case (job_q)
						J_CAB: begin
							cab_q   <= res[shc_pkg::MulAW-1:0];
							state_q <= (scount_q == '0) ? S_PASS_END : S_RD_FIRST;
						end
						J_SIDE: begin
							if (side_first_q) begin
								s_q     <= e_q;
								s_in_q  <= res[shc_pkg::AccW-1];
								i_q     <= '0;
								// A single vertex closes on itself.
								state_q <= (scount_q == shc_pkg::CntW'(1)) ? S_LAT_E : S_RD_E;
							end else begin
								e_in_q  <= res[shc_pkg::AccW-1];
								state_q <= S_DECIDE;
							end
						end
						J_CPQ: begin
							cpq_q   <= res[shc_pkg::MulAW-1:0];
							job_q   <= J_DEN;
							state_q <= S_JOB0;
						end
						J_DEN: begin
							den_q   <= res[shc_pkg::DenW-1:0];
							job_q   <= J_NUMX;
							state_q <= S_JOB0;
						end
						default: begin
							// Numerator ready: load the divider.
							nq_q       <= num_mag;
							dmag_q     <= den_mag;
							rem_q      <= '0;
							div_neg_q  <= res[shc_pkg::AccW-1] ^ den_q[shc_pkg::DenW-1];
							div_zero_q <= (den_q == '0);
							div_y_q    <= (job_q == J_NUMY);
							div_cnt_q  <= shc_pkg::DivCntW'(shc_pkg::AccW);
							state_q    <= S_DIV;
						end
					endcase
				end
				S_RD_FIRST: state_q <= S_LAT_FIRST;
				S_LAT_FIRST: begin
					first_q      <= subj_rd;
					e_q          <= subj_rd;
					side_first_q <= 1'b1;
					job_q        <= J_SIDE;
					state_q      <= S_JOB0;
				end
				S_RD_E: state_q <= S_LAT_E;
				S_LAT_E: begin
					e_q          <= last_e ? first_q : subj_rd;
					side_first_q <= 1'b0;
					job_q        <= J_SIDE;
					state_q      <= S_JOB0;
				end
				S_DECIDE: begin
					if (s_in_q != e_in_q) begin
						job_q   <= J_CPQ;
						state_q <= S_JOB0;
					end else if (s_in_q) begin
						state_q <= S_PUSH_E;
					end else begin
						state_q <= S_ADV;
					end
				end
				S_DIV: begin
					if (div_cnt_q != '0) begin
						rem_q     <= q_bit ? shc_pkg::DenW'(rem_sh - {1'b0, dmag_q})
						                   : rem_sh[shc_pkg::DenW-1:0];
						nq_q      <= {nq_q[shc_pkg::AccW-2:0], q_bit};
						div_cnt_q <= div_cnt_q - 1'b1;
					end else if (!div_y_q) begin
						ivert_q.x <= quot;
						job_q     <= J_NUMY;
						state_q   <= S_JOB0;
					end else begin
						ivert_q.y <= quot;
						state_q   <= S_PUSH_I;
					end
				end
				S_PUSH_I, S_PUSH_E: begin
					if (push_en) begin
						m_q <= m_q + 1'b1;
					end else begin
						ovf_q <= 1'b1;
					end
					state_q <= (state_q == S_PUSH_I && e_in_q) ? S_PUSH_E : S_ADV;
				end
				S_ADV: begin
					s_q     <= e_q;
					s_in_q  <= e_in_q;
					i_q     <= i_q + 1'b1;
					// The last subject edge has just been handled.
					state_q <= last_e ? S_PASS_END
						: (((i_q + shc_pkg::CntW'(2)) == scount_q) ? S_LAT_E : S_RD_E);
				end
				S_PASS_END: begin
					scount_q <= m_q;
					m_q      <= '0;
					bank_q   <= !bank_q;
					p_q      <= p_next;
					state_q  <= (p_next == ccount_q) ? S_EMIT_RD : S_CRD_A;
				end
				S_EMIT_RD: begin
					if (scount_q == '0) begin
						out_vert_q  <= '0;
						out_last_q  <= 1'b1;
						out_empty_q <= 1'b1;
						out_ovf_q   <= ovf_q;
						out_valid_q <= 1'b1;
						state_q     <= S_EMIT_WAIT;
					end else begin
						state_q <= S_EMIT_LAT;
					end
				end
				S_EMIT_LAT: begin
					out_vert_q  <= subj_rd;
					out_last_q  <= ((k_q + 1'b1) == scount_q);
					out_empty_q <= 1'b0;
					out_ovf_q   <= ovf_q;
					out_valid_q <= 1'b1;
					state_q     <= S_EMIT_WAIT;
				end
				S_EMIT_WAIT: begin
					if (m_tready) begin
						out_valid_q <= 1'b0;
						if (out_last_q) begin
							// Drop the polygon and clipper, back to loading.
							scount_q <= '0;
							ccount_q <= '0;
							ovf_q    <= 1'b0;
							state_q  <= S_IDLE;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_EMIT_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = shc_pkg::DataW'(out_vert_q);
	assign m_tlast  = out_last_q;
	always_comb begin
		m_tuser                   = '0;
		m_tuser[shc_pkg::UserEmpty] = out_empty_q;
		m_tuser[shc_pkg::UserOvf]   = out_ovf_q;
	end

	`SHC_ASSERT_NOW(a_no_overlap, m_tvalid, !s_tready, "output word while input open")
	`SHC_ASSERT_NOW(a_scount_range, 1'b1, scount_q <= shc_pkg::CntW'(shc_pkg::MaxVerts), "subject count beyond store")
	`SHC_ASSERT_NOW(a_push_range, 1'b1, m_q <= shc_pkg::CntW'(shc_pkg::MaxVerts), "pass count beyond store")
	`SHC_ASSERT_NOW(a_empty_last, m_tvalid && m_tuser[shc_pkg::UserEmpty], m_tlast, "empty word without last")
	`SHC_ASSERT_NEXT(a_clip_busy, in_acc && (in_act == shc_pkg::ACT_CLIP), !s_tready, "input open after clip word")

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for polygon_clip_sutherland_hodgman_core.
// Loads subject and clipper polygons, issues clip words and compares every
// emitted vertex with an in-bench clipper model. Depends on shc_pkg and the core.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [shc_pkg::SUserW-1:0] ACT_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 6000000;
	localparam int CB = shc_pkg::CoordBits;

	typedef struct {
		int x;
		int y;
	} pt_t;

	typedef struct {
		logic [CB-1:0] x;
		logic [CB-1:0] y;
		logic last;
		logic empty;
		logic ovf;
	} clip_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [shc_pkg::DataW-1:0] s_tdata = '0;
	logic [shc_pkg::SUserW-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [shc_pkg::DataW-1:0] m_tdata;
	logic [shc_pkg::MUserW-1:0] m_tuser;
	logic m_tlast;

	// Model state: current subject, clipper outline, overflow flag.
	pt_t subj_pts[$];
	pt_t clip_pts[$];
	bit subj_ovf;
	clip_word_t pending_verts[$];

	int errors = 0;
	int clip_words = 0;
	int verts_seen = 0;
	int cycles = 0;
	bit steady = 1'b0;   // suppress idling on both sides

	polygon_clip_sutherland_hodgman_core uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic longint edge_side(pt_t a, pt_t b, pt_t p);
		return (longint'(b.x) - a.x) * (longint'(p.y) - a.y)
		     - (longint'(b.y) - a.y) * (longint'(p.x) - a.x);
	endfunction

	function automatic int div_clamp(longint num, longint den);
		longint q;
		if (den == 0)
			return 0;
		q = num / den;
		if (q > (2 ** (CB - 1)) - 1) q = (2 ** (CB - 1)) - 1;
		if (q < -(2 ** (CB - 1))) q = -(2 ** (CB - 1));
		return int'(q);
	endfunction

	// Crossing point of the line a-b with the line p-q.
	function automatic pt_t line_cross(pt_t a, pt_t b, pt_t p, pt_t q);
		longint cab, cpq, dxab, dyab, dxpq, dypq, den;
		pt_t r;
		cab = longint'(a.x) * b.y - longint'(a.y) * b.x;
		cpq = longint'(p.x) * q.y - longint'(p.y) * q.x;
		dxab = longint'(a.x) - b.x;
		dyab = longint'(a.y) - b.y;
		dxpq = longint'(p.x) - q.x;
		dypq = longint'(p.y) - q.y;
		den = dxab * dypq - dyab * dxpq;
		r.x = div_clamp(cab * dxpq - dxab * cpq, den);
		r.y = div_clamp(cab * dypq - dyab * cpq, den);
		return r;
	endfunction

	function automatic void keep_vertex(ref pt_t dst[$], input pt_t v);
		if (dst.size() < shc_pkg::MaxVerts)
			dst.push_back(v);
		else
			subj_ovf = 1'b1;
	endfunction

	// One pass of the subject against clipper edge a->b.
	function automatic void clip_edge(pt_t a, pt_t b);
		pt_t nxt[$];
		pt_t s, e;
		bit s_in, e_in;
		int n;
		n = subj_pts.size();
		for (int i = 0; i < n; i++) begin
			s = subj_pts[i];
			e = subj_pts[(i + 1) % n];
			s_in = edge_side(a, b, s) < 0;
			e_in = edge_side(a, b, e) < 0;
			if (s_in && e_in) begin
				keep_vertex(nxt, e);
			end else if (!s_in && e_in) begin
				keep_vertex(nxt, line_cross(a, b, s, e));
				keep_vertex(nxt, e);
			end else if (s_in && !e_in) begin
				keep_vertex(nxt, line_cross(a, b, s, e));
			end
		end
		subj_pts = nxt;
	endfunction

	// Apply one accepted input word to the model.
	function automatic void predict_word(logic [1:0] act, pt_t v);
		clip_word_t w;
		int n;
		case (act)
			shc_pkg::ACT_LOAD_SUBJ: begin
				if (subj_pts.size() < shc_pkg::MaxVerts)
					subj_pts.push_back(v);
				else
					subj_ovf = 1'b1;
			end
			shc_pkg::ACT_LOAD_CLIP: begin
				if (clip_pts.size() < shc_pkg::MaxClipVerts)
					clip_pts.push_back(v);
			end
			shc_pkg::ACT_CLIP: begin
				n = clip_pts.size();
				for (int i = 0; i < n; i++)
					clip_edge(clip_pts[i], clip_pts[(i + 1) % n]);
				if (subj_pts.size() == 0) begin
					w = '{x: '0, y: '0, last: 1'b1, empty: 1'b1, ovf: subj_ovf};
					pending_verts.push_back(w);
				end else begin
					foreach (subj_pts[i]) begin
						w.x = subj_pts[i].x[CB-1:0];
						w.y = subj_pts[i].y[CB-1:0];
						w.last = (i == subj_pts.size() - 1);
						w.empty = 1'b0;
						w.ovf = subj_ovf;
						pending_verts.push_back(w);
					end
				end
				subj_pts.delete();
				clip_pts.delete();
				subj_ovf = 1'b0;
				clip_words++;
			end
			default: ;
		endcase
	endfunction

	// Send one word; hold it until accepted, then update the model.
	task automatic send_word(logic [1:0] act, int x, int y);
		pt_t v;
		if (!steady && $urandom_range(99) < 9) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {y[CB-1:0], x[CB-1:0]};
		do @(posedge clk); while (!s_tready);
		v.x = $signed(x[CB-1:0]);
		v.y = $signed(y[CB-1:0]);
		predict_word(act, v);
	endtask

	task automatic load_poly(logic [1:0] act, int n);
		for (int i = 0; i < n; i++)
			send_word(act, $urandom_range(4095) - 2048, $urandom_range(4095) - 2048);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_verts.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Receiver: stall at random, none during a steady stretch.
	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(99) >= 19);
	end

	// Compare each accepted vertex with the oldest expectation.
	always @(posedge clk) begin
		clip_word_t w;
		if (arst_n && m_tvalid && m_tready) begin
			verts_seen++;
			if (pending_verts.size() == 0) begin
				errors++;
				$display("%t unexpected vertex x=%0h y=%0h user=%b last=%b", $realtime,
					m_tdata[CB-1:0], m_tdata[2*CB-1:CB], m_tuser, m_tlast);
			end else begin
				w = pending_verts.pop_front();
				if (m_tdata[CB-1:0] !== w.x) begin
					errors++;
					$display("%t out_x exp %0h got %0h", $realtime, w.x, m_tdata[CB-1:0]);
				end
				if (m_tdata[2*CB-1:CB] !== w.y) begin
					errors++;
					$display("%t out_y exp %0h got %0h", $realtime, w.y, m_tdata[2*CB-1:CB]);
				end
				if (m_tlast !== w.last) begin
					errors++;
					$display("%t last exp %b got %b", $realtime, w.last, m_tlast);
				end
				if (m_tuser[shc_pkg::UserEmpty] !== w.empty) begin
					errors++;
					$display("%t empty exp %b got %b", $realtime, w.empty,
						m_tuser[shc_pkg::UserEmpty]);
				end
				if (m_tuser[shc_pkg::UserOvf] !== w.ovf) begin
					errors++;
					$display("%t overflow exp %b got %b", $realtime, w.ovf,
						m_tuser[shc_pkg::UserOvf]);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%t timeout, %0d vertices still expected", $realtime, pending_verts.size());
			$display("** polygon_clip_sutherland_hodgman_core: FAILED **");
			$finish;
		end
	end

	// Square clip of a triangle, unused action, coordinate extremes.
	task automatic test_basic();
		send_word(shc_pkg::ACT_LOAD_SUBJ, -2048, -2048);
		send_word(shc_pkg::ACT_LOAD_SUBJ, 2047, 0);
		send_word(shc_pkg::ACT_LOAD_SUBJ, 0, 2047);
		send_word(ACT_UNUSED, 5, 5);
		send_word(shc_pkg::ACT_LOAD_CLIP, -1000, -1000);
		send_word(shc_pkg::ACT_LOAD_CLIP, -1000, 1000);
		send_word(shc_pkg::ACT_LOAD_CLIP, 1000, 1000);
		send_word(shc_pkg::ACT_LOAD_CLIP, 1000, -1000);
		send_word(shc_pkg::ACT_CLIP, 0, 0);
		drain();
	endtask

	// Empty subject, no clipper, single clipper vertex.
	task automatic test_degenerate();
		send_word(shc_pkg::ACT_CLIP, 0, 0);
		send_word(shc_pkg::ACT_LOAD_SUBJ, 2047, 2047);
		send_word(shc_pkg::ACT_LOAD_SUBJ, -2048, 2047);
		send_word(shc_pkg::ACT_CLIP, 0, 0);
		send_word(shc_pkg::ACT_LOAD_SUBJ, 10, 10);
		send_word(shc_pkg::ACT_LOAD_SUBJ, 20, -30);
		send_word(shc_pkg::ACT_LOAD_CLIP, 100, 100);
		send_word(shc_pkg::ACT_CLIP, 0, 0);
		drain();
	endtask

	// Zigzag subject across a line overflows the pass output; extra loads
	// overflow the subject and clipper stores.
	task automatic test_overflow();
		for (int i = 0; i < shc_pkg::MaxVerts; i++)
			send_word(shc_pkg::ACT_LOAD_SUBJ, i * 100 - 1600, (i % 2) ? 1000 : -1000);
		send_word(shc_pkg::ACT_LOAD_CLIP, -2048, 0);
		send_word(shc_pkg::ACT_LOAD_CLIP, 2047, 0);
		send_word(shc_pkg::ACT_CLIP, 0, 0);
		drain();
		load_poly(shc_pkg::ACT_LOAD_SUBJ, shc_pkg::MaxVerts + 2);
		load_poly(shc_pkg::ACT_LOAD_CLIP, shc_pkg::MaxClipVerts + 2);
		send_word(shc_pkg::ACT_CLIP, 0, 0);
		drain();
	endtask

	// Random polygons: mostly small, a few up to full size, some noise words.
	task automatic test_random();
		int ns, nc;
		for (int k = 0; k < 12; k++) begin
			steady = (k >= 5 && k < 8);
			ns = ($urandom_range(9) == 0) ? $urandom_range(shc_pkg::MaxVerts)
				: $urandom_range(1, 6);
			nc = ($urandom_range(9) == 0) ? $urandom_range(shc_pkg::MaxClipVerts)
				: $urandom_range(0, 5);
			load_poly(shc_pkg::ACT_LOAD_SUBJ, ns);
			if ($urandom_range(4) == 0)
				send_word(ACT_UNUSED, $urandom_range(4095), $urandom_range(4095));
			load_poly(shc_pkg::ACT_LOAD_CLIP, nc);
			send_word(shc_pkg::ACT_CLIP, $urandom_range(4095), $urandom_range(4095));
		end
		steady = 1'b0;
		drain();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_basic();
		test_degenerate();
		test_overflow();
		test_random();
		repeat (200) @(posedge clk);
		$display("Ran %0d clip words, checked %0d emitted vertices", clip_words, verts_seen);
		$display("including empty, unclipped, degenerate and overflow cases.");
		if (errors == 0 && pending_verts.size() == 0) begin
			$display("** polygon_clip_sutherland_hodgman_core: PASSED **");
		end else begin
			$display("** polygon_clip_sutherland_hodgman_core: FAILED **");
		end
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+design
design/shc_pkg.sv
design/shc_ram.sv
design/polygon_clip_sutherland_hodgman_core.sv
verif/testbench.sv
